@@ rtl/pctd_pkg.sv @@
// Shared types, constants and the hex digit function for the percent-escape decoder.
`timescale 1ns / 1ps

package pctd_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam int HEX_RADIX = 16;
	localparam int DIGIT_BITS = $clog2(HEX_RADIX);
	localparam int MAX_BYTES = 3;
	localparam int CNT_BITS = $clog2(MAX_BYTES + 1);

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_final;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_final;
	} out_word_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	typedef struct packed {
		logic                                  ok;
		logic [DIGIT_BITS-1:0]                 value;
	} hex_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]                   count;
		logic [MAX_BYTES-1:0][7:0]             bytes;
		phase_t                                next_phase;
		logic [7:0]                            next_held;
	} step_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = DIGIT_BITS'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = DIGIT_BITS'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = DIGIT_BITS'(c - 8'h61 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

@@ rtl/pctd_step.sv @@
// Decode logic for one input word: released bytes and the next escape state.
`timescale 1ns / 1ps

module pctd_step (
	input  pctd_pkg::in_word_t word,
	input  pctd_pkg::phase_t   phase,
	input  logic [7:0]         held,
	output pctd_pkg::step_t    step
);

	pctd_pkg::hex_t cur_hex;
	pctd_pkg::hex_t held_hex;
	logic           starts_escape;

	assign cur_hex = pctd_pkg::hex_value(word.in_char);
	assign held_hex = pctd_pkg::hex_value(held);
	// At the end of a string a '%' cannot open an escape, so it is released as is.
	assign starts_escape = (word.in_char == pctd_pkg::PCT_CHAR) && !word.in_final;

	always_comb begin
		step.count = '0;
		step.bytes = '0;
		step.next_phase = pctd_pkg::PH_IDLE;
		step.next_held = word.in_final ? 8'h00 : held;
		case (phase)
			pctd_pkg::PH_PCT: begin
				if (cur_hex.ok) begin
					if (word.in_final) begin
						step.count = pctd_pkg::CNT_BITS'(2);
						step.bytes[0] = pctd_pkg::PCT_CHAR;
						step.bytes[1] = word.in_char;
					end else begin
						step.next_phase = pctd_pkg::PH_DIGIT;
						step.next_held = word.in_char;
					end
				end else begin
					step.bytes[0] = pctd_pkg::PCT_CHAR;
					if (starts_escape) begin
						step.count = pctd_pkg::CNT_BITS'(1);
						step.next_phase = pctd_pkg::PH_PCT;
					end else begin
						step.count = pctd_pkg::CNT_BITS'(2);
						step.bytes[1] = word.in_char;
					end
				end
			end
			pctd_pkg::PH_DIGIT: begin
				step.next_held = 8'h00;
				if (cur_hex.ok) begin
					step.count = pctd_pkg::CNT_BITS'(1);
					step.bytes[0] = {held_hex.value, cur_hex.value};
				end else begin
					step.bytes[0] = pctd_pkg::PCT_CHAR;
					step.bytes[1] = held;
					if (starts_escape) begin
						step.count = pctd_pkg::CNT_BITS'(2);
						step.next_phase = pctd_pkg::PH_PCT;
					end else begin
						step.count = pctd_pkg::CNT_BITS'(3);
						step.bytes[2] = word.in_char;
					end
				end
			end
			default: begin
				if (starts_escape) begin
					step.next_phase = pctd_pkg::PH_PCT;
				end else begin
					step.count = pctd_pkg::CNT_BITS'(1);
					step.bytes[0] = word.in_char;
				end
			end
		endcase
	end

endmodule

@@ rtl/percent_escape_decoder.sv @@
// Top level of the streaming percent-escape decoder.
`timescale 1ns / 1ps
//
// The src channel takes one raw byte per word, with in_final set on the last
// byte of a string. The dst channel gives decoded bytes, with out_final set on
// the last byte released by a final input word. A '%' with two hex digits
// becomes one byte; anything else passes through literally.
// An accepted word is held in an input register, is decoded in one pass,
// and loads a result buffer of up to three bytes that drains one byte per
// cycle while dst is ready. The first byte of a word appears on dst once the
// word has passed the input register and been loaded into the result buffer.
// The rate is one word per cycle while each word releases at most one byte
// and dst is ready. After a word that releases two or three bytes, the next
// word waits in the input register until the buffer's last byte is taken.
// Words that release nothing (an escape's start) never hold up the next word.
// Reset clears the escape state and empties both registers; src_ready is high
// right after reset. When dst stalls, the buffer holds its bytes, the input
// register fills, and src_ready falls until the buffer can take its next load.

module percent_escape_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  pctd_pkg::in_word_t   src_word,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output pctd_pkg::out_word_t  dst_word
);

	logic                                          valid_s1;
	pctd_pkg::in_word_t                            word_s1;
	pctd_pkg::phase_t                              phase_q;
	logic [7:0]                                    held_q;
	logic [pctd_pkg::MAX_BYTES-1:0][7:0]           buf_q;
	logic [pctd_pkg::CNT_BITS-1:0]                 count_q;
	logic                                          final_q;
	pctd_pkg::step_t                               step;
	logic                                          take;
	logic                                          load;

	pctd_step u_step (
		.word  (word_s1),
		.phase (phase_q),
		.held  (held_q),
		.step  (step)
	);

	assign take = dst_valid && dst_ready;
	assign load = valid_s1 && ((count_q == '0) ||
		((count_q == pctd_pkg::CNT_BITS'(1)) && take));
	assign src_ready = !valid_s1 || load;

	assign dst_valid = (count_q != '0);
	assign dst_word.out_char = buf_q[0];
	assign dst_word.out_final = final_q && (count_q == pctd_pkg::CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			word_s1 <= src_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pctd_pkg::PH_IDLE;
			held_q <= 8'h00;
			count_q <= '0;
		end else if (load) begin
			phase_q <= step.next_phase;
			held_q <= step.next_held;
			count_q <= step.count;
		end else if (take) begin
			count_q <= count_q - pctd_pkg::CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= step.bytes;
			final_q <= word_s1.in_final;
		end else if (take) begin
			for (int i = 0; i < pctd_pkg::MAX_BYTES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[pctd_pkg::MAX_BYTES-1] <= 8'h00;
		end
	end

endmodule

@@ rtl/pctd_checker.sv @@
// Port-level checks for the percent-escape decoder, bound to its top level.
`timescale 1ns / 1ps

module pctd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_ready,
	input pctd_pkg::in_word_t  src_word,
	input logic                dst_valid,
	input logic                dst_ready,
	input pctd_pkg::out_word_t dst_word
);

	// A stalled result word keeps its value until it is taken.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
		else $error("dst word changed while stalled");

	// A stalled input word stays offered and unchanged until it is taken.
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_ready |=> src_valid && $stable(src_word))
		else $error("src word changed while stalled");

	// The input side only stalls behind a pending result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> dst_valid)
		else $error("src stalled with no result pending");

	// Reset leaves the block empty and open for input.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !dst_valid && src_ready)
		else $error("block not empty after reset");

endmodule

bind percent_escape_decoder pctd_checker u_pctd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_ready (src_ready),
	.src_word  (src_word),
	.dst_valid (dst_valid),
	.dst_ready (dst_ready),
	.dst_word  (dst_word)
);
